[rtl/core/lzw_compressor_12bit_top_defines.svh]
// Assertion macros shared by the LZW compressor RTL.
`ifndef LZW_COMPRESSOR_12BIT_TOP_DEFINES_SVH
`define LZW_COMPRESSOR_12BIT_TOP_DEFINES_SVH

// Same-cycle implication, checked on clk, off while in reset.
`define LZWC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk, off while in reset.
`define LZWC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/lzwc_pkg.sv]
// Shared constants and types of the LZW compressor.
package lzwc_pkg;

    // Code and dictionary geometry
    localparam int CODE_BITS  = 12;
    localparam int HASH_SLOTS = 5021;
    localparam int BYTE_W     = 8;
    localparam int BYTE_SHIFT = CODE_BITS - BYTE_W;
    localparam int ADDR_W     = $clog2(HASH_SLOTS);
    localparam int FREE_W     = CODE_BITS + 1;

    localparam logic [ADDR_W-1:0]    SLOTS_A    = ADDR_W'(HASH_SLOTS);
    localparam logic [CODE_BITS-1:0] END_CODE   = CODE_BITS'(256);
    localparam logic [FREE_W-1:0]    FIRST_FREE = FREE_W'(257);
    localparam logic [FREE_W-1:0]    LAST_CODE  = FREE_W'((1 << CODE_BITS) - 1);

    // Input queue (depth is a power of two so the pointers wrap by themselves)
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Bit packer: up to seven leftover bits plus one code
    localparam int BUF_W = CODE_BITS + BYTE_W - 1;
    localparam int CNT_W = $clog2(BUF_W + 1);

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              has_byte;
        logic              end_of_input;
    } item_t;

    // Dictionary slot as stored in RAM
    typedef struct packed {
        logic                 valid;
        logic [BYTE_W-1:0]    data;
        logic [CODE_BITS-1:0] parent;
        logic [CODE_BITS-1:0] code;
    } entry_t;

    localparam int WORD_W = $bits(entry_t);

    // Up to three codes handed to the packer, flush pads and ends the stream
    typedef struct packed {
        logic [1:0]           n;
        logic                 flush;
        logic [CODE_BITS-1:0] c0;
        logic [CODE_BITS-1:0] c1;
        logic [CODE_BITS-1:0] c2;
    } job_t;

endpackage

[rtl/core/lzw_compressor_12bit_top.sv]
// LZW compressor with fixed 12-bit codes, packed MSB first into bytes.
// Each input word carries at most one byte and an end mark; words with
// neither are dropped. Words go into a 4-deep queue, so input is taken even
// while the dictionary engine or output is busy, until the queue fills.
// A byte that extends the current string takes a queue pop with hash read,
// then a slot check, plus a further slot check per extra collision probe in
// the single-read-port dictionary RAM. A byte that ends a string also hands
// its code to the packer; the packer takes the code, then appends it, then
// sends 1 or 2 output bytes at one per cycle while the output does not
// stall, and goes idle before it takes the next code.
// After reset and after every end of stream the dictionary is cleared by a
// sweep over all 5021 slots, one slot per cycle; words are queued but not
// processed during the sweep. At end of stream the pending code, the end
// code 256 and a zero-padded partial byte are sent; stream_done marks the
// last byte, last_of_run the last byte caused by each input word.
module lzw_compressor_12bit_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       has_byte,
    input  logic       end_of_input,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last_of_run,
    output logic       stream_done
);

    logic                              q_valid;
    lzwc_pkg::item_t                   q_item;
    logic                              q_pop;
    logic                              ram_we;
    logic [lzwc_pkg::ADDR_W-1:0]       ram_waddr;
    logic [lzwc_pkg::WORD_W-1:0]       ram_wdata;
    logic [lzwc_pkg::ADDR_W-1:0]       ram_raddr;
    logic [lzwc_pkg::WORD_W-1:0]       ram_rdata;
    logic                              job_valid;
    lzwc_pkg::job_t                    job;
    logic                              job_ready;

    // Input queue
    lzwc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .has_byte     (has_byte),
        .end_of_input (end_of_input),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    // Dictionary engine
    lzwc_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .job_valid (job_valid),
        .job       (job),
        .job_ready (job_ready)
    );

    // Dictionary storage
    lzwc_ram #(
        .WIDTH (lzwc_pkg::WORD_W),
        .DEPTH (lzwc_pkg::HASH_SLOTS)
    ) u_dict (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output packing
    lzwc_packer u_packer (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (job_valid),
        .job         (job),
        .job_ready   (job_ready),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .stream_done (stream_done)
    );

endmodule

[rtl/core/lzwc_ram.sv]
// Generic simple dual-port RAM, one write port, one registered read port.
module lzwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/lzwc_front.sv]
// Input side: takes words, drops empty ones, queues the rest for the engine.
module lzwc_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             data_byte,
    input  logic                   has_byte,
    input  logic                   end_of_input,
    output logic                   q_valid,
    output lzwc_pkg::item_t        q_item,
    input  logic                   q_pop
);

    lzwc_pkg::item_t                  q_mem [lzwc_pkg::QUEUE_DEPTH];
    logic [lzwc_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [lzwc_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [lzwc_pkg::QPTR_W:0]        count_reg, count_next;
    logic                             push;

    assign in_stall = (count_reg == (lzwc_pkg::QPTR_W+1)'(lzwc_pkg::QUEUE_DEPTH));

    // A word with neither a byte nor an end mark has no effect: not queued
    assign push = in_valid && !in_stall && (has_byte || end_of_input);

    assign q_valid = (count_reg != '0);
    assign q_item  = q_mem[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= '{data_byte: data_byte, has_byte: has_byte,
                                   end_of_input: end_of_input};
        end
    end

`include "lzw_compressor_12bit_top_defines.svh"

    `LZWC_ASSERT_NOW(a_queue_bound, 1'b1, count_reg <= (lzwc_pkg::QPTR_W+1)'(lzwc_pkg::QUEUE_DEPTH), "input queue overfilled")
    `LZWC_ASSERT_NOW(a_pop_nonempty, q_pop, count_reg != '0, "pop from empty input queue")

endmodule

[rtl/core/lzwc_engine.sv]
// Dictionary engine: hashed lookup, insertion, clearing sweep, code jobs.
module lzwc_engine (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  lzwc_pkg::item_t                     q_item,
    output logic                                q_pop,
    output logic                                ram_we,
    output logic [lzwc_pkg::ADDR_W-1:0]         ram_waddr,
    output logic [lzwc_pkg::WORD_W-1:0]         ram_wdata,
    output logic [lzwc_pkg::ADDR_W-1:0]         ram_raddr,
    input  logic [lzwc_pkg::WORD_W-1:0]         ram_rdata,
    output logic                                job_valid,
    output lzwc_pkg::job_t                      job,
    input  logic                                job_ready
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_CMP   = 2'd2;
    localparam logic [1:0] ST_POST  = 2'd3;

    logic [1:0]                          state_reg, state_next;
    logic [lzwc_pkg::CODE_BITS-1:0]      prefix_reg, prefix_next;
    logic                                have_reg, have_next;
    logic [lzwc_pkg::FREE_W-1:0]         free_code_reg, free_code_next;
    logic [lzwc_pkg::BYTE_W-1:0]         cur_byte_reg, cur_byte_next;
    logic                                cur_end_reg, cur_end_next;
    logic [lzwc_pkg::ADDR_W-1:0]         idx_reg, idx_next;
    logic [lzwc_pkg::ADDR_W-1:0]         step_reg, step_next;
    logic [lzwc_pkg::ADDR_W-1:0]         probe_n_reg, probe_n_next;
    logic [lzwc_pkg::ADDR_W-1:0]         clr_idx_reg, clr_idx_next;
    lzwc_pkg::job_t                      job_reg, job_next;

    logic [lzwc_pkg::CODE_BITS-1:0]      home_code;
    logic [lzwc_pkg::ADDR_W-1:0]         home_idx;
    logic [lzwc_pkg::ADDR_W-1:0]         home_step;
    logic [lzwc_pkg::ADDR_W-1:0]         nxt_idx;
    lzwc_pkg::entry_t                    rd_entry;
    lzwc_pkg::entry_t                    wr_entry;
    logic                                hit;
    logic                                slot_free;
    logic                                exhausted;

    // Home slot: (byte << (CODE_BITS-8)) ^ prefix. It never reaches
    // HASH_SLOTS (more slots than codes), so no wrap is needed here.
    assign home_code = {q_item.data_byte, {lzwc_pkg::BYTE_SHIFT{1'b0}}} ^ prefix_reg;
    assign home_idx  = {{(lzwc_pkg::ADDR_W-lzwc_pkg::CODE_BITS){1'b0}}, home_code};
    assign home_step = (home_idx == '0) ? lzwc_pkg::ADDR_W'(1)
                                         : lzwc_pkg::SLOTS_A - home_idx;

    // Next probe slot, wrapping modulo HASH_SLOTS
    assign nxt_idx = (idx_reg >= step_reg) ? idx_reg - step_reg
                                           : idx_reg + (lzwc_pkg::SLOTS_A - step_reg);

    // Slot check on the registered read data
    assign rd_entry  = lzwc_pkg::entry_t'(ram_rdata);
    assign hit       = rd_entry.valid && (rd_entry.parent == prefix_reg)
                       && (rd_entry.data == cur_byte_reg);
    assign slot_free = !rd_entry.valid;
    assign exhausted = (probe_n_reg == lzwc_pkg::SLOTS_A - 1'b1);

    assign wr_entry = '{valid: 1'b1, data: cur_byte_reg, parent: prefix_reg,
                        code: free_code_reg[lzwc_pkg::CODE_BITS-1:0]};

    assign job_valid = (state_reg == ST_POST);
    assign job       = job_reg;

    // Control sequence
    always_comb
    begin
        state_next     = state_reg;
        prefix_next    = prefix_reg;
        have_next      = have_reg;
        free_code_next = free_code_reg;
        cur_byte_next  = cur_byte_reg;
        cur_end_next   = cur_end_reg;
        idx_next       = idx_reg;
        step_next      = step_reg;
        probe_n_next   = probe_n_reg;
        clr_idx_next   = clr_idx_reg;
        job_next       = job_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = wr_entry;
        ram_raddr      = idx_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_idx_reg;
                ram_wdata    = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == lzwc_pkg::SLOTS_A - 1'b1)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                ram_raddr = home_idx;
                if (q_valid)
                begin
                    q_pop         = 1'b1;
                    cur_byte_next = q_item.data_byte;
                    cur_end_next  = q_item.end_of_input;
                    if (q_item.has_byte && have_reg)
                    begin
                        idx_next     = home_idx;
                        step_next    = home_step;
                        probe_n_next = '0;
                        state_next   = ST_CMP;
                    end
                    else if (q_item.has_byte)
                    begin
                        // first byte of a stream starts the string
                        prefix_next = lzwc_pkg::CODE_BITS'(q_item.data_byte);
                        have_next   = 1'b1;
                        if (q_item.end_of_input)
                        begin
                            job_next   = '{n: 2'd2, flush: 1'b1,
                                           c0: lzwc_pkg::CODE_BITS'(q_item.data_byte),
                                           c1: lzwc_pkg::END_CODE, c2: '0};
                            state_next = ST_POST;
                        end
                    end
                    else
                    begin
                        // end only: an empty stream sends the end code twice
                        job_next   = '{n: 2'd2, flush: 1'b1,
                                       c0: have_reg ? prefix_reg : lzwc_pkg::END_CODE,
                                       c1: lzwc_pkg::END_CODE, c2: '0};
                        state_next = ST_POST;
                    end
                end
            end

            ST_CMP:
            begin
                if (hit)
                begin
                    prefix_next = rd_entry.code;
                    if (cur_end_reg)
                    begin
                        job_next   = '{n: 2'd2, flush: 1'b1, c0: rd_entry.code,
                                       c1: lzwc_pkg::END_CODE, c2: '0};
                        state_next = ST_POST;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (slot_free || exhausted)
                begin
                    // miss: store the new string if a slot and a code remain
                    if (slot_free && (free_code_reg <= lzwc_pkg::LAST_CODE))
                    begin
                        ram_we         = 1'b1;
                        free_code_next = free_code_reg + 1'b1;
                    end
                    if (cur_end_reg)
                    begin
                        job_next = '{n: 2'd3, flush: 1'b1, c0: prefix_reg,
                                     c1: lzwc_pkg::CODE_BITS'(cur_byte_reg),
                                     c2: lzwc_pkg::END_CODE};
                    end
                    else
                    begin
                        job_next = '{n: 2'd1, flush: 1'b0, c0: prefix_reg,
                                     c1: '0, c2: '0};
                    end
                    prefix_next = lzwc_pkg::CODE_BITS'(cur_byte_reg);
                    state_next  = ST_POST;
                end
                else
                begin
                    // collision: probe the next slot
                    ram_raddr    = nxt_idx;
                    idx_next     = nxt_idx;
                    probe_n_next = probe_n_reg + 1'b1;
                end
            end

            ST_POST:
            begin
                if (job_ready)
                begin
                    if (job_reg.flush)
                    begin
                        prefix_next    = '0;
                        have_next      = 1'b0;
                        free_code_next = lzwc_pkg::FIRST_FREE;
                        clr_idx_next   = '0;
                        state_next     = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            prefix_reg    <= '0;
            have_reg      <= 1'b0;
            free_code_reg <= lzwc_pkg::FIRST_FREE;
            clr_idx_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            prefix_reg    <= prefix_next;
            have_reg      <= have_next;
            free_code_reg <= free_code_next;
            clr_idx_reg   <= clr_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_byte_reg <= cur_byte_next;
        cur_end_reg  <= cur_end_next;
        idx_reg      <= idx_next;
        step_reg     <= step_next;
        probe_n_reg  <= probe_n_next;
        job_reg      <= job_next;
    end

`include "lzw_compressor_12bit_top_defines.svh"

    `LZWC_ASSERT_NOW(a_dict_cap, ram_we && (state_reg == ST_CMP), free_code_reg <= lzwc_pkg::LAST_CODE, "dictionary insert past last code")
    `LZWC_ASSERT_NEXT(a_flush_clears, (state_reg == ST_POST) && job_ready && job_reg.flush, (state_reg == ST_CLEAR) && (clr_idx_reg == '0) && !have_reg, "end of stream did not restart clearing")

endmodule

[rtl/core/lzwc_packer.sv]
// Bit packer: packs codes MSB first into bytes and drives the output word.
module lzwc_packer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  job_valid,
    input  lzwc_pkg::job_t        job,
    output logic                  job_ready,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            out_byte,
    output logic                  last_of_run,
    output logic                  stream_done
);

    logic                                busy_reg, busy_next;
    logic                                flush_reg, flush_next;
    logic [1:0]                          pq_n_reg, pq_n_next;
    logic [lzwc_pkg::CODE_BITS-1:0]      pq0_reg, pq0_next;
    logic [lzwc_pkg::CODE_BITS-1:0]      pq1_reg, pq1_next;
    logic [lzwc_pkg::CODE_BITS-1:0]      pq2_reg, pq2_next;
    logic [lzwc_pkg::BUF_W-1:0]          buf_reg, buf_next;
    logic [lzwc_pkg::CNT_W-1:0]          cnt_reg, cnt_next;
    logic                                out_valid_reg, out_valid_next;
    logic [lzwc_pkg::BYTE_W-1:0]         out_byte_reg, out_byte_next;
    logic                                last_reg, last_next;
    logic                                done_reg, done_next;

    logic                                can_out;
    logic                                have_byte;
    logic [lzwc_pkg::CNT_W-1:0]          rem;
    logic [lzwc_pkg::BUF_W-1:0]          code_aligned;

    localparam logic [lzwc_pkg::CNT_W-1:0] CNT_BYTE = lzwc_pkg::CNT_W'(lzwc_pkg::BYTE_W);
    localparam logic [lzwc_pkg::CNT_W-1:0] CNT_CODE = lzwc_pkg::CNT_W'(lzwc_pkg::CODE_BITS);

    assign can_out   = !out_valid_reg || !out_stall;
    assign have_byte = (cnt_reg >= CNT_BYTE);
    assign rem       = cnt_reg - CNT_BYTE;
    assign job_ready = !busy_reg;

    // Next code lined up behind the bits already held
    assign code_aligned = {pq0_reg, {(lzwc_pkg::BUF_W-lzwc_pkg::CODE_BITS){1'b0}}}
                          >> cnt_reg;

    always_comb
    begin
        busy_next      = busy_reg;
        flush_next     = flush_reg;
        pq_n_next      = pq_n_reg;
        pq0_next       = pq0_reg;
        pq1_next       = pq1_reg;
        pq2_next       = pq2_reg;
        buf_next       = buf_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        done_next      = done_reg;

        if (!busy_reg)
        begin
            // take a new job
            if (job_valid)
            begin
                busy_next  = 1'b1;
                flush_next = job.flush;
                pq_n_next  = job.n;
                pq0_next   = job.c0;
                pq1_next   = job.c1;
                pq2_next   = job.c2;
            end
        end
        else if (have_byte)
        begin
            // a full byte is ready
            if (can_out)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = buf_reg[lzwc_pkg::BUF_W-1 -: lzwc_pkg::BYTE_W];
                last_next      = (rem < CNT_BYTE) && (pq_n_reg == 2'd0)
                                 && !(flush_reg && (rem != '0));
                done_next      = last_next && flush_reg;
                buf_next       = buf_reg << lzwc_pkg::BYTE_W;
                cnt_next       = rem;
            end
        end
        else if (pq_n_reg != 2'd0)
        begin
            // append the next code
            buf_next  = buf_reg | code_aligned;
            cnt_next  = cnt_reg + CNT_CODE;
            pq0_next  = pq1_reg;
            pq1_next  = pq2_reg;
            pq_n_next = pq_n_reg - 1'b1;
        end
        else if (flush_reg && (cnt_reg != '0))
        begin
            // partial byte at end of stream, zero padded
            if (can_out)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = buf_reg[lzwc_pkg::BUF_W-1 -: lzwc_pkg::BYTE_W];
                last_next      = 1'b1;
                done_next      = 1'b1;
                buf_next       = '0;
                cnt_next       = '0;
                busy_next      = 1'b0;
            end
        end
        else
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pq_n_reg      <= '0;
            buf_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pq_n_reg      <= pq_n_next;
            buf_reg       <= buf_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flush_reg    <= flush_next;
        pq0_reg      <= pq0_next;
        pq1_reg      <= pq1_next;
        pq2_reg      <= pq2_next;
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
        done_reg     <= done_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;
    assign stream_done = done_reg;

`include "lzw_compressor_12bit_top_defines.svh"

    `LZWC_ASSERT_NOW(a_rack_room, 1'b1, cnt_reg <= lzwc_pkg::CNT_W'(lzwc_pkg::BUF_W), "bit buffer overflow")
    `LZWC_ASSERT_NEXT(a_flush_empties, busy_reg && !busy_next && flush_reg, cnt_reg == '0, "stream ended with bits left in buffer")

endmodule

[bench/tb_lzw_compressor_12bit_top.sv]
// Self-checking testbench for the 12-bit LZW compressor top level.
module tb_lzw_compressor_12bit_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES  = 600;
    localparam int RANDOM_WORDS = 120;
    localparam int SETTLE_WAIT  = 64;

    // One compressed byte as seen on the output channel
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       stream_done;
    } packed_byte_t;

    // Kinds of text used for random streams
    typedef enum int {
        TEXT_ANY,
        TEXT_FEW,
        TEXT_RUNS
    } text_kind_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_input;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       stream_done;

    // Bench controls shared by the tests and the output side
    bit tx_idle_en;
    bit rx_idle_en;
    bit hold_request;
    int mismatch_count;

    // Expected compressed bytes, oldest first
    packed_byte_t expected_bytes[$];

    // Dictionary model and stream state
    bit                             dict_used  [lzwc_pkg::HASH_SLOTS];
    logic [lzwc_pkg::CODE_BITS-1:0] dict_parent[lzwc_pkg::HASH_SLOTS];
    logic [7:0]                     dict_char  [lzwc_pkg::HASH_SLOTS];
    logic [lzwc_pkg::CODE_BITS-1:0] dict_code  [lzwc_pkg::HASH_SLOTS];
    logic [lzwc_pkg::CODE_BITS-1:0] cur_prefix;
    bit                             prefix_live;
    logic [lzwc_pkg::FREE_W-1:0]    free_code;
    logic [7:0]                     rack;
    int unsigned                    rack_fill;
    logic [7:0]                     word_bytes[$];

    lzw_compressor_12bit_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .has_byte     (has_byte),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .last_of_run  (last_of_run),
        .stream_done  (stream_done)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Fresh dictionary, no pending string, empty bit rack
    function automatic void restart_stream();
        foreach (dict_used[i])
            dict_used[i] = 1'b0;
        cur_prefix  = '0;
        prefix_live = 1'b0;
        free_code   = lzwc_pkg::FIRST_FREE;
        rack        = '0;
        rack_fill   = 0;
    endfunction

    // Pack one code MSB first; full bytes go to word_bytes
    function automatic void append_code(input logic [lzwc_pkg::CODE_BITS-1:0] code);
        for (int b = lzwc_pkg::CODE_BITS - 1; b >= 0; b--)
        begin
            if (code[b])
                rack[7 - rack_fill] = 1'b1;
            rack_fill++;
            if (rack_fill == 8)
            begin
                word_bytes.push_back(rack);
                rack      = '0;
                rack_fill = 0;
            end
        end
    endfunction

    // Open-addressing lookup: matching or free slot, -1 if none
    function automatic int find_slot(input logic [lzwc_pkg::CODE_BITS-1:0] parent,
                                     input logic [7:0] ch);
        int idx;
        int step;
        idx  = ((int'(ch) << (lzwc_pkg::CODE_BITS - 8)) ^ int'(parent))
               % lzwc_pkg::HASH_SLOTS;
        step = (idx == 0) ? 1 : lzwc_pkg::HASH_SLOTS - idx;
        for (int n = 0; n < lzwc_pkg::HASH_SLOTS; n++)
        begin
            if (!dict_used[idx])
                return idx;
            if (dict_parent[idx] == parent && dict_char[idx] == ch)
                return idx;
            idx = (idx >= step) ? idx - step : idx + lzwc_pkg::HASH_SLOTS - step;
        end
        return -1;
    endfunction

    // Compress one accepted word and queue the bytes it should produce
    function automatic void compress_word(input logic [7:0] data, input logic has,
                                          input logic eoi);
        int           slot;
        packed_byte_t exp_byte;
        word_bytes.delete();
        if (has)
        begin
            if (!prefix_live)
            begin
                cur_prefix  = lzwc_pkg::CODE_BITS'(data);
                prefix_live = 1'b1;
            end
            else
            begin
                slot = find_slot(cur_prefix, data);
                if (slot >= 0 && dict_used[slot])
                    cur_prefix = dict_code[slot];
                else
                begin
                    // miss: learn the new string unless the table is full
                    if (slot >= 0 && free_code <= lzwc_pkg::LAST_CODE)
                    begin
                        dict_used[slot]   = 1'b1;
                        dict_parent[slot] = cur_prefix;
                        dict_char[slot]   = data;
                        dict_code[slot]   = free_code[lzwc_pkg::CODE_BITS-1:0];
                        free_code++;
                    end
                    append_code(cur_prefix);
                    cur_prefix = lzwc_pkg::CODE_BITS'(data);
                end
            end
        end
        if (eoi)
        begin
            // empty stream sends the end code in place of a prefix
            if (!prefix_live)
                cur_prefix = lzwc_pkg::END_CODE;
            append_code(cur_prefix);
            append_code(lzwc_pkg::END_CODE);
            if (rack_fill != 0)
                word_bytes.push_back(rack);
            restart_stream();
        end
        foreach (word_bytes[k])
        begin
            exp_byte.out_byte    = word_bytes[k];
            exp_byte.last_of_run = (k == word_bytes.size() - 1);
            exp_byte.stream_done = (k == word_bytes.size() - 1) && eoi;
            expected_bytes.push_back(exp_byte);
        end
    endfunction

    // Offer one word, wait for it to be taken, then maybe idle
    task automatic feed_word(input logic [7:0] data, input logic has, input logic eoi);
        in_valid     <= 1'b1;
        data_byte    <= data;
        has_byte     <= has;
        end_of_input <= eoi;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        compress_word(data, has, eoi);
        if (tx_idle_en && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18))
                @(posedge clk);
        end
    endtask

    // Stop offering and wait until every expected byte has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
    endtask

    // Output side: random stall bursts and the long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                hold_request = 1'b0;
                out_stall <= 1'b0;
            end
            else if (rx_idle_en && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18))
                    @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Compare each accepted output byte with the oldest expectation
    always @(posedge clk)
    begin : check_output
        packed_byte_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_bytes.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("%0t: unexpected byte %02h last_of_run %0b stream_done %0b",
                             $realtime, out_byte, last_of_run, stream_done);
                mismatch_count++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (out_byte !== want.out_byte || last_of_run !== want.last_of_run ||
                    stream_done !== want.stream_done)
                begin
                    if (mismatch_count < 10)
                        $display("%0t: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                                 $realtime, want.out_byte, want.last_of_run,
                                 want.stream_done, out_byte, last_of_run, stream_done);
                    mismatch_count++;
                end
            end
        end
    end

    // End marker with no data: end code goes out twice
    task automatic test_empty_stream();
        feed_word(8'h00, 1'b0, 1'b1);
        wait_drained();
    endtask

    // First byte and end in the same word
    task automatic test_single_byte_stream();
        feed_word(8'hFF, 1'b1, 1'b1);
        wait_drained();
    endtask

    // Alternating extreme bytes build and then hit dictionary strings
    task automatic test_byte_extremes();
        for (int i = 0; i < 7; i++)
            feed_word((i % 2 == 0) ? 8'h00 : 8'hFF, 1'b1, 1'b0);
        feed_word(8'hA5, 1'b0, 1'b1);
        wait_drained();
    endtask

    // Runs of one byte with dropped words mixed in
    task automatic test_runs_and_dropped_words();
        for (int i = 0; i < 8; i++)
        begin
            if (i == 3)
                feed_word(8'hFF, 1'b0, 1'b0);
            if (i == 6)
                feed_word(8'h00, 1'b0, 1'b0);
            feed_word(8'h41, 1'b1, 1'b0);
        end
        feed_word(8'h41, 1'b1, 1'b1);
        wait_drained();
    endtask

    // Hold the output long enough for the input queue to back up
    task automatic test_output_backpressure();
        feed_word(8'h41, 1'b1, 1'b0);
        feed_word(8'h42, 1'b1, 1'b0);
        feed_word(8'h43, 1'b1, 1'b0);
        wait_drained();
        hold_request = 1'b1;
        while (!out_stall)
            @(posedge clk);
        for (int i = 0; i < 40; i++)
            feed_word(8'($urandom), 1'b1, 1'b0);
        feed_word(8'($urandom), 1'b1, 1'b1);
        wait_drained();
    endtask

    // Random streams of mixed length and content, with idling on both sides
    task automatic test_random_streams();
        int         words_left;
        int         len;
        bit         merge_end;
        text_kind_t kind;
        logic [7:0] base;
        logic [7:0] ch;
        words_left = RANDOM_WORDS;
        while (words_left > 0)
        begin
            tx_idle_en = ($urandom_range(0, 2) != 0);
            rx_idle_en = ($urandom_range(0, 2) != 0);
            len        = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
            merge_end  = (len > 0) && ($urandom_range(0, 1) == 1);
            kind       = text_kind_t'($urandom_range(0, 2));
            base       = 8'($urandom);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 11) == 0)
                    feed_word(8'($urandom), 1'b0, 1'b0);
                case (kind)
                    TEXT_ANY:  ch = 8'($urandom);
                    TEXT_FEW:  ch = base + 8'($urandom_range(0, 2));
                    TEXT_RUNS: ch = ($urandom_range(0, 3) == 0) ? ~base : base;
                    default:   ch = base;
                endcase
                feed_word(ch, 1'b1, (i == len - 1) && merge_end);
            end
            if (!merge_end)
                feed_word(8'($urandom), 1'b0, 1'b1);
            words_left -= len + (merge_end ? 0 : 1);
        end
        wait_drained();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
    endtask

    // Back-to-back words with no idling on either side
    task automatic test_back_to_back();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        for (int i = 0; i < 24; i++)
            feed_word(8'h61 + 8'($urandom_range(0, 3)), 1'b1, 1'b0);
        feed_word(8'($urandom), 1'b1, 1'b1);
        wait_drained();
    endtask

    // Test sequence
    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        data_byte    = 8'h00;
        has_byte     = 1'b0;
        end_of_input = 1'b0;
        restart_stream();
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_stream();
        test_single_byte_stream();
        test_byte_extremes();
        test_runs_and_dropped_words();
        test_output_backpressure();
        test_random_streams();
        test_back_to_back();

        repeat (SETTLE_WAIT)
            @(posedge clk);
        if (mismatch_count == 0 && expected_bytes.size() == 0)
            $display("lzw_compressor_12bit_top regression: pass");
        else
            $display("lzw_compressor_12bit_top regression: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #100_000_000;
        $display("lzw_compressor_12bit_top regression: fail");
        $finish;
    end

endmodule
